// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while reset is held
`define WSTP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication, sampled on aclk, off while reset is held
`define WSTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ----- sv/wstp_pkg.sv -----
`timescale 1ns / 1ps
package wstp_pkg;

    localparam int DEF_NUM_SECTIONS = 8;
    localparam logic [15:0] FPW_RESET = 16'd30;
    localparam int FPS_SCALE = 1000;
    localparam int QW = 24;

    localparam logic [1:0] MODE_BEGIN = 2'd0;
    localparam logic [1:0] MODE_END   = 2'd1;
    localparam logic [1:0] MODE_FRAME = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  section;
        logic [31:0] timestamp_ms;
    } in_t;

    typedef struct packed {
        logic [2:0]  result_section;
        logic [31:0] busy_ms;
        logic [31:0] entry_count;
        logic [15:0] busy_share_q16;
        logic [31:0] window_ms;
        logic [23:0] fps_q8;
        logic        last;
    } out_t;

    typedef struct packed {
        logic exec;
        logic mul;
        logic div_start;
        logic div_sel_fps;
        logic fps_latch;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic close;
        logic div_done;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- sv/wstp_div.sv -----
`timescale 1ns / 1ps
module wstp_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num_hi,
    input  logic [wstp_pkg::QW-1:0] num_lo,
    input  logic [31:0] den,
    output logic        done,
    output logic [wstp_pkg::QW-1:0] quot
);
    import wstp_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0]   rem_reg;
    logic [QW-1:0] lo_reg;
    logic [QW-1:0] q_reg;
    logic [32:0]   trial;
    logic          qbit;

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, lo_reg[QW-1]};
    assign qbit  = (trial >= {1'b0, den});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            // high part not below divisor: quotient overflows, also covers zero
            busy_reg <= (num_hi < den);
            done_reg <= (num_hi >= den);
            cnt_reg  <= CW'(QW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num_hi;
            lo_reg  <= num_lo;
            q_reg   <= (num_hi >= den) ? '1 : '0;
        end else if (busy_reg) begin
            rem_reg <= qbit ? 32'(trial - {1'b0, den}) : trial[31:0];
            lo_reg  <= {lo_reg[QW-2:0], 1'b0};
            q_reg   <= {q_reg[QW-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

// ----- sv/wstp_dp.sv -----
`timescale 1ns / 1ps
module wstp_dp #(
    parameter int NUM_SECTIONS = wstp_pkg::DEF_NUM_SECTIONS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              ev_load,
    input  wstp_pkg::in_t     ev_in,
    input  wstp_pkg::dp_cmd_t cmd,
    input  logic [((NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1)-1:0] idx,
    output wstp_pkg::dp_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output wstp_pkg::out_t    m_data
);
    import wstp_pkg::*;

    localparam int IW    = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int STORE = (NUM_SECTIONS < 8) ? NUM_SECTIONS : 8;
    localparam int SW    = (STORE > 1) ? $clog2(STORE) : 1;

    logic [31:0] start_reg [STORE];
    logic [31:0] busy_reg  [STORE];
    logic [31:0] ent_reg   [STORE];
    logic [15:0] fc_reg;
    logic [15:0] fpw_reg;
    logic [31:0] wstart_reg;
    logic        m_valid_reg;

    in_t         ev_reg;
    logic [31:0] window_reg;
    logic [16:0] frames_reg;
    logic [26:0] num_reg;
    logic [23:0] fps_reg;
    out_t        m_data_reg;

    logic [15:0]   fc_inc;
    logic          ev_hit;
    logic [SW-1:0] ev_idx;
    logic [31:0]   elapsed;
    logic [32:0]   busy_sum;
    logic          close_w;
    logic [SW-1:0] wi;
    logic          w_in;
    logic [31:0]   busy_w;
    logic [31:0]   ent_w;
    logic [31:0]   div_hi;
    logic [QW-1:0] div_lo;
    logic          div_done;
    logic [QW-1:0] div_q;
    logic          out_free;

    assign fc_inc   = fc_reg + 16'd1;
    assign ev_hit   = (32'(ev_reg.section) < NUM_SECTIONS);
    assign ev_idx   = ev_reg.section[SW-1:0];
    assign elapsed  = ev_reg.timestamp_ms - start_reg[ev_idx];
    assign busy_sum = {1'b0, busy_reg[ev_idx]} + {1'b0, elapsed};
    assign close_w  = (ev_reg.mode == MODE_FRAME) && (fc_inc == fpw_reg);

    // sections past the stored ones never see an event and read as zero
    assign wi     = idx[SW-1:0];
    assign w_in   = (32'(idx) < STORE);
    assign busy_w = w_in ? busy_reg[wi] : 32'd0;
    assign ent_w  = w_in ? ent_reg[wi] : 32'd0;

    assign div_hi = cmd.div_sel_fps ? 32'(num_reg[26:16]) : {8'd0, busy_w[31:8]};
    assign div_lo = cmd.div_sel_fps ? {num_reg[15:0], 8'd0} : {busy_w[7:0], 16'd0};

    wstp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num_hi  (div_hi),
        .num_lo  (div_lo),
        .den     (window_reg),
        .done    (div_done),
        .quot    (div_q)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE; i++) begin
                start_reg[i] <= '0;
                busy_reg[i]  <= '0;
                ent_reg[i]   <= '0;
            end
            fc_reg      <= '0;
            fpw_reg     <= FPW_RESET;
            wstart_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                fpw_reg <= cfg_wr_data;
            end
            if (cmd.exec) begin
                case (ev_reg.mode)
                    MODE_BEGIN: begin
                        if (ev_hit) begin
                            start_reg[ev_idx] <= ev_reg.timestamp_ms;
                            if (ent_reg[ev_idx] != '1) begin
                                ent_reg[ev_idx] <= ent_reg[ev_idx] + 32'd1;
                            end
                        end
                    end
                    MODE_END: begin
                        if (ev_hit) begin
                            busy_reg[ev_idx] <= busy_sum[32] ? '1 : busy_sum[31:0];
                        end
                    end
                    MODE_FRAME: begin
                        if (close_w) begin
                            fc_reg     <= '0;
                            wstart_reg <= ev_reg.timestamp_ms;
                        end else begin
                            fc_reg <= fc_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.load_out && w_in) begin
                busy_reg[wi] <= '0;
                ent_reg[wi]  <= '0;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_load) begin
            ev_reg <= ev_in;
        end
        if (cmd.exec && close_w) begin
            window_reg <= ev_reg.timestamp_ms - wstart_reg;
            frames_reg <= (fpw_reg == 16'd0) ? 17'h10000 : {1'b0, fpw_reg};
        end
        if (cmd.mul) begin
            num_reg <= {10'd0, frames_reg} * 27'(FPS_SCALE);
        end
        if (cmd.fps_latch) begin
            fps_reg <= div_q;
        end
        if (cmd.load_out) begin
            m_data_reg.result_section <= 3'(idx);
            m_data_reg.busy_ms        <= busy_w;
            m_data_reg.entry_count    <= ent_w;
            m_data_reg.busy_share_q16 <= (div_q[QW-1:16] != '0) ? 16'hFFFF : div_q[15:0];
            m_data_reg.window_ms      <= window_reg;
            m_data_reg.fps_q8         <= fps_reg;
            m_data_reg.last           <= (idx == IW'(NUM_SECTIONS - 1));
        end
    end

    assign sts.close    = close_w;
    assign sts.div_done = div_done;
    assign sts.out_free = out_free;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
endmodule

// ----- sv/wstp_ctrl.sv -----
`timescale 1ns / 1ps
module wstp_ctrl #(
    parameter int NUM_SECTIONS = wstp_pkg::DEF_NUM_SECTIONS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wstp_pkg::dp_sts_t sts,
    output wstp_pkg::dp_cmd_t cmd,
    output logic [((NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1)-1:0] idx
);
    import wstp_pkg::*;

    localparam int IW = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_FPS_GO,
        ST_FPS_WAIT,
        ST_SEC_GO,
        ST_SEC_WAIT,
        ST_LOAD
    } state_t;

    state_t        state_reg;
    logic          s_ready_reg;
    logic [IW-1:0] idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            idx_reg     <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_EXEC;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    if (sts.close) begin
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_FPS_GO;
                end
                ST_FPS_GO: begin
                    state_reg <= ST_FPS_WAIT;
                end
                ST_FPS_WAIT: begin
                    if (sts.div_done) begin
                        state_reg <= ST_SEC_GO;
                        idx_reg   <= '0;
                    end
                end
                ST_SEC_GO: begin
                    state_reg <= ST_SEC_WAIT;
                end
                ST_SEC_WAIT: begin
                    if (sts.div_done) begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    // wait for the result register to drain
                    if (sts.out_free) begin
                        if (idx_reg == IW'(NUM_SECTIONS - 1)) begin
                            state_reg   <= ST_IDLE;
                            s_ready_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_SEC_GO;
                            idx_reg   <= idx_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        cmd             = '0;
        cmd.exec        = (state_reg == ST_EXEC);
        cmd.mul         = (state_reg == ST_MUL);
        cmd.div_start   = (state_reg == ST_FPS_GO) || (state_reg == ST_SEC_GO);
        cmd.div_sel_fps = (state_reg == ST_FPS_GO);
        cmd.fps_latch   = (state_reg == ST_FPS_WAIT) && sts.div_done;
        cmd.load_out    = (state_reg == ST_LOAD) && sts.out_free;
    end

    assign s_ready = s_ready_reg;
    assign idx     = idx_reg;
endmodule

// ----- sv/windowed_section_time_profiler.sv -----
`timescale 1ns / 1ps
// channel   ports                        payload
// ------    ---------------------------  -------------------------------
// event in  s_valid / s_ready / s_data   mode, section, timestamp_ms
// result    m_valid / m_ready / m_data   one per section on window close
// config    cfg_wr_en / cfg_wr_data      frames_per_window, no wait
//
// begin, end and plain frame events are accepted, then applied in an update state.
// a closing frame adds the multiply and the fps divide, then per section a
// divide on the shared 24-step restoring divider plus a load before its result.
// each result waits in the output register until taken; m_ready low stalls
// the section walk, and no new event is taken until the last is loaded.
// reset (aresetn low, synchronous) clears all section totals, counts and start times.
module windowed_section_time_profiler #(
    parameter int NUM_SECTIONS = wstp_pkg::DEF_NUM_SECTIONS
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [15:0]     cfg_wr_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  wstp_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output wstp_pkg::out_t  m_data
);
    import wstp_pkg::*;

    localparam int IW = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

    dp_cmd_t       cmd;
    dp_sts_t       sts;
    logic [IW-1:0] idx;
    logic          s_accept;

    assign s_accept = s_valid && s_ready;

    wstp_ctrl #(
        .NUM_SECTIONS (NUM_SECTIONS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd),
        .idx     (idx)
    );

    wstp_dp #(
        .NUM_SECTIONS (NUM_SECTIONS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ev_load     (s_accept),
        .ev_in       (s_data),
        .cmd         (cmd),
        .idx         (idx),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );
endmodule

// ----- sv/wstp_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wstp_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input wstp_pkg::out_t m_data
);
    import wstp_pkg::*;

    // a stalled result transaction holds
    `WSTP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // an accepted event closes the input in the next cycle
    `WSTP_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)

    // while the section walk is mid-window, no event is taken
    `WSTP_ASSERT_NOW(a_walk_blocks_input, m_valid && !m_data.last, !s_ready)
endmodule

bind windowed_section_time_profiler wstp_checker u_wstp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
